// ----- rtl/ltd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ltd_pkg
// Shared types and constants of the LZ77 token decoder.
// ---------------------------------------------------------------------------
package ltd_pkg;

   localparam int OFFSET_W = 12;
   localparam int LENGTH_W = 6;
   localparam int BYTE_W   = 8;

   // history entries that were never written read as a caret
   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h5E;

   // classified token: count is the number of bytes actually copied
   typedef struct packed {
      logic [OFFSET_W-1:0] match_offset;
      logic [LENGTH_W-1:0] count;
      logic [BYTE_W-1:0]   literal_byte;
   } token_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/ltd_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ltd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ltd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/ltd_fifo.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ltd_fifo
// Small register FIFO with fill level, used for the token and result queues.
// ---------------------------------------------------------------------------
module ltd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [WIDTH-1:0]           wr_data,
   output      logic                       full,
   input  wire logic                       rd_en,
   output      logic [WIDTH-1:0]           rd_data,
   output      logic                       empty,
   output      logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int IW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [IW-1:0]    wr_ptr_ff;
   logic [IW-1:0]    rd_ptr_ff;
   logic [LW-1:0]    level_ff;
   logic             do_wr;
   logic             do_rd;
   logic [IW-1:0]    wr_ptr_in;
   logic [IW-1:0]    rd_ptr_in;

   assign full    = level_ff == LW'(DEPTH);
   assign empty   = level_ff == '0;
   assign level   = level_ff;
   assign rd_data = data_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   assign wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         if (do_wr && !do_rd) begin
            level_ff <= level_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            level_ff <= level_ff - 1'b1;
         end
      end
      if (do_wr) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ltd_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ltd_front
// Token intake: clamps the match length, cuts the copy at the window end and
// queues the classified token for the sequencer.
// ---------------------------------------------------------------------------
module ltd_front
   import ltd_pkg::*;
#(
   parameter int WINDOW      = 4096,
   parameter int MAX_MATCH   = 63,
   parameter int TOKEN_DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output      logic                full,
   input  wire logic [OFFSET_W-1:0] req_match_offset,
   input  wire logic [LENGTH_W-1:0] req_match_length,
   input  wire logic [BYTE_W-1:0]   req_literal_byte,
   output      logic                tok_valid,
   output      token_type           tok,
   input  wire logic                tok_pop
);

   localparam int AW = $clog2(WINDOW);
   localparam int CW = ((AW + 1) > (OFFSET_W + 1)) ? (AW + 1) : (OFFSET_W + 1);
   localparam int QLW = $clog2(TOKEN_DEPTH + 1);
   localparam logic [LENGTH_W-1:0] MAX_LEN = LENGTH_W'(MAX_MATCH);

   logic [LENGTH_W-1:0]        len_sat;
   logic [CW-1:0]              offset_ext;
   logic [CW-1:0]              room;
   logic [LENGTH_W-1:0]        count;
   token_type                  tok_in;
   logic                       tok_empty;
   logic [$bits(token_type)-1:0] tok_bits;
   logic [QLW-1:0]             tok_level;

   assign len_sat    = (req_match_length > MAX_LEN) ? MAX_LEN : req_match_length;
   assign offset_ext = CW'(req_match_offset);
   assign room       = CW'(WINDOW) - offset_ext;

   always_comb begin
      if (len_sat == '0 || offset_ext >= CW'(WINDOW)) begin
         count = '0;
      end else if (CW'(len_sat) < room) begin
         count = len_sat;
      end else begin
         count = room[LENGTH_W-1:0];
      end
   end

   assign tok_in.match_offset = req_match_offset;
   assign tok_in.count        = count;
   assign tok_in.literal_byte = req_literal_byte;

   ltd_fifo #(
      .WIDTH ($bits(token_type)),
      .DEPTH (TOKEN_DEPTH)
   ) u_token_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (tok_in),
      .full    (full),
      .rd_en   (tok_pop),
      .rd_data (tok_bits),
      .empty   (tok_empty),
      .level   (tok_level)
   );

   assign tok       = token_type'(tok_bits);
   assign tok_valid = !tok_empty;

   always_ff @(posedge clock) begin
      if (!reset && tok_level > QLW'(TOKEN_DEPTH)) begin
         $error("token queue level out of range");
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ltd_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ltd_back
// Copy sequencer: walks the history RAM for the match, then issues the
// literal; every byte goes to the result queue and back into the history.
// ---------------------------------------------------------------------------
module ltd_back
   import ltd_pkg::*;
#(
   parameter int WINDOW       = 4096,
   parameter int RESULT_DEPTH = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                tok_valid,
   input  wire token_type                           tok,
   output      logic                                tok_pop,
   input  wire logic [$clog2(RESULT_DEPTH+1)-1:0]   res_level,
   output      logic                                res_push,
   output      result_type                          res
);

   localparam int AW = $clog2(WINDOW);
   localparam int SW = ((AW > OFFSET_W) ? AW : OFFSET_W) + 1;
   localparam int LW = $clog2(RESULT_DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_COPY, ST_LIT} state_type;

   state_type           state_ff;
   logic [AW-1:0]       ptr_ff;      // oldest byte, next write position
   logic [AW-1:0]       ptr_in;
   logic                wrapped_ff;  // every history entry written at least once
   logic [AW-1:0]       addr_ff;
   logic [AW-1:0]       addr_in;
   logic [LENGTH_W-1:0] cnt_ff;
   logic [BYTE_W-1:0]   lit_ff;

   logic                s1_valid_ff;
   logic                s1_last_ff;
   logic                s1_ok_ff;
   logic [BYTE_W-1:0]   s1_lit_ff;
   logic [AW-1:0]       s1_waddr_ff;

   logic [SW-1:0]       base_sum;
   logic [AW-1:0]       base_addr;
   logic                credit;
   logic                issue_copy;
   logic                issue_lit;
   logic [BYTE_W-1:0]   lit_src;
   logic                rd_ok;
   logic [BYTE_W-1:0]   ram_rdata;
   logic [BYTE_W-1:0]   s1_byte;

   assign base_sum  = SW'(ptr_ff) + SW'(tok.match_offset);
   assign base_addr = (base_sum >= SW'(WINDOW)) ? AW'(base_sum - SW'(WINDOW)) : AW'(base_sum);
   assign ptr_in    = (ptr_ff == AW'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
   assign addr_in   = (addr_ff == AW'(WINDOW - 1)) ? '0 : addr_ff + 1'b1;

   // room for this issue plus the one still in the read stage
   assign credit = ((LW + 1)'(res_level) + (LW + 1)'(s1_valid_ff)) < (LW + 1)'(RESULT_DEPTH);

   // unwritten entries lie at or beyond the write position until the first wrap
   assign rd_ok   = wrapped_ff || (addr_ff < ptr_ff);
   assign lit_src = (state_ff == ST_IDLE) ? tok.literal_byte : lit_ff;

   always_comb begin
      tok_pop    = 1'b0;
      issue_copy = 1'b0;
      issue_lit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (tok_valid && credit) begin
               tok_pop   = 1'b1;
               issue_lit = tok.count == '0;
            end
         end
         ST_COPY: begin
            issue_copy = credit;
         end
         ST_LIT: begin
            issue_lit = credit;
         end
         default: begin
            tok_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ptr_ff      <= '0;
         wrapped_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue_copy || issue_lit;
         if (issue_copy || issue_lit) begin
            ptr_ff <= ptr_in;
            if (ptr_ff == AW'(WINDOW - 1)) begin
               wrapped_ff <= 1'b1;
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (tok_pop && tok.count != '0) begin
                  addr_ff  <= base_addr;
                  cnt_ff   <= tok.count;
                  lit_ff   <= tok.literal_byte;
                  state_ff <= ST_COPY;
               end
            end
            ST_COPY: begin
               if (issue_copy) begin
                  addr_ff <= addr_in;
                  cnt_ff  <= cnt_ff - 1'b1;
                  if (cnt_ff == LENGTH_W'(1)) begin
                     state_ff <= ST_LIT;
                  end
               end
            end
            ST_LIT: begin
               if (issue_lit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      s1_last_ff  <= issue_lit;
      s1_ok_ff    <= rd_ok;
      s1_lit_ff   <= lit_src;
      s1_waddr_ff <= ptr_ff;
   end

   ltd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_waddr_ff),
      .wr_data (s1_byte),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign s1_byte      = s1_last_ff ? s1_lit_ff : (s1_ok_ff ? ram_rdata : FILL_BYTE);
   assign res_push     = s1_valid_ff;
   assign res.out_byte = s1_byte;
   assign res.last     = s1_last_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (res_level < LW'(RESULT_DEPTH)))
      else $error("result pushed into a full queue");

   a_copy_not_last: assert property (@(posedge clock) disable iff (reset)
      issue_copy |=> (s1_valid_ff && !s1_last_ff))
      else $error("copied byte flagged as last");

   a_pop_in_idle: assert property (@(posedge clock) disable iff (reset)
      tok_pop |-> (state_ff == ST_IDLE))
      else $error("token taken while a token is in progress");

   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (cnt_ff != '0))
      else $error("copy state with zero count");

endmodule
`default_nettype wire

// ----- rtl/lz77_token_decoder_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lz77_token_decoder_unit
// LZ77 token decoder: one token in, its copied bytes and literal out.
// ---------------------------------------------------------------------------
// A token whose match length is zero (or whose offset lies outside the window)
// issues only its literal as it is taken. A token that copies n bytes is
// handled in steps: the token is taken and the start address formed, then
// each copied byte is read through the single read port of the history RAM,
// then the literal is issued. Output bytes leave at up to one per cycle through
// a small result queue; when it fills, the sequencer holds. The history comes
// up as all carets with no clearing pass: a write pointer and a wrap flag mark
// which entries were written, and entries not yet written read as a caret.
module lz77_token_decoder_unit
   import ltd_pkg::*;
#(
   parameter int WINDOW       = 4096,
   parameter int MAX_MATCH    = 63,
   parameter int TOKEN_DEPTH  = 4,
   parameter int RESULT_DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output      logic                full,
   input  wire logic [OFFSET_W-1:0] req_match_offset,
   input  wire logic [LENGTH_W-1:0] req_match_length,
   input  wire logic [BYTE_W-1:0]   req_literal_byte,
   output      logic                empty,
   input  wire logic                pop,
   output      logic [BYTE_W-1:0]   rsp_out_byte,
   output      logic                rsp_last
);

   logic                              tok_valid;
   token_type                         tok;
   logic                              tok_pop;
   logic                              res_push;
   result_type                        res;
   logic                              res_full;
   logic [$bits(result_type)-1:0]     res_bits;
   result_type                        res_head;
   logic [$clog2(RESULT_DEPTH+1)-1:0] res_level;

   ltd_front #(
      .WINDOW      (WINDOW),
      .MAX_MATCH   (MAX_MATCH),
      .TOKEN_DEPTH (TOKEN_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_match_offset (req_match_offset),
      .req_match_length (req_match_length),
      .req_literal_byte (req_literal_byte),
      .tok_valid        (tok_valid),
      .tok              (tok),
      .tok_pop          (tok_pop)
   );

   ltd_back #(
      .WINDOW       (WINDOW),
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok       (tok),
      .tok_pop   (tok_pop),
      .res_level (res_level),
      .res_push  (res_push),
      .res       (res)
   );

   ltd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (res_bits),
      .empty   (empty),
      .level   (res_level)
   );

   assign res_head     = result_type'(res_bits);
   assign rsp_out_byte = res_head.out_byte;
   assign rsp_last     = res_head.last;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result transfer lost at a full queue");

endmodule
`default_nettype wire
